// ===== rtl/rsr_pkg.sv =====
// Shared types, codes and constants for the request shard router.
package rsr_pkg;

	localparam int POOL_SLOTS_DEF = 256;
	localparam int CFG_W          = 9;
	localparam int HASH_W         = 64;
	localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
	localparam int HASH_SHIFT     = 5;
	localparam int IDX_W          = 32;
	localparam int KEY_W          = 8;
	localparam int SLOT_W         = 8;

	// Remainder unit: dividend bits retired per cycle
	localparam int DIG_BITS  = 4;
	localparam int MOD_STEPS = HASH_W / DIG_BITS;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);

	// Stream packing
	localparam int S_TDATA_W = 104;	// matrix, row, column, key byte
	localparam int S_TUSER_W = 6;	// item kind, attribute kind, key empty
	localparam int M_TDATA_W = 8;	// slot
	localparam int M_TUSER_W = 2;	// status

	// Item kinds
	localparam logic [2:0] IK_MATRIX = 3'd0;
	localparam logic [2:0] IK_ROW    = 3'd1;
	localparam logic [2:0] IK_COLUMN = 3'd2;
	localparam logic [2:0] IK_CELL   = 3'd3;
	localparam logic [2:0] IK_KV     = 3'd4;

	// Attribute kinds
	localparam logic [1:0] AK_INDEX = 2'd0;
	localparam logic [1:0] AK_NAME  = 2'd1;

	typedef enum logic [1:0] {
		RS_OK      = 2'd0,
		RS_RANGE   = 2'd1,
		RS_NAME    = 2'd2,
		RS_UNKNOWN = 2'd3
	} status_t;

	typedef struct packed {
		logic              start;
		logic [HASH_W-1:0] dividend;
	} mod_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mod_sts_t;

endpackage

// ===== rtl/rsr_hash.sv =====
// Running 64-bit djb2 hash of the key bytes of one request.
module rsr_hash (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        upd,
	input  logic                        clr,
	input  logic [rsr_pkg::KEY_W-1:0]   key_byte,
	output logic [rsr_pkg::HASH_W-1:0]  hash
);
	import rsr_pkg::*;

	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] key_ext;

	assign key_ext = {{(HASH_W-KEY_W){key_byte[KEY_W-1]}}, key_byte};
	// hash*33 + byte, wrapping
	assign hash = upd ? ((hash_q << HASH_SHIFT) + hash_q + key_ext) : hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_SEED;
		end else if (clr) begin
			hash_q <= HASH_SEED;
		end else if (upd) begin
			hash_q <= hash;
		end
	end

endmodule

// ===== rtl/rsr_mod.sv =====
// Iterative remainder unit: 64-bit dividend mod a narrow divisor, a digit per cycle.
module rsr_mod #(
	parameter int SIZE_W = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rsr_pkg::mod_req_t    req,
	input  logic [SIZE_W-1:0]    divisor,
	output rsr_pkg::mod_sts_t    sts,
	output logic [SIZE_W-1:0]    remainder
);
	import rsr_pkg::*;

	logic [HASH_W-1:0]    dvd_q;
	logic [SIZE_W-1:0]    div_q;
	logic [SIZE_W-1:0]    rem_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [SIZE_W-1:0]    rem_nxt;

	// restoring steps over the next DIG_BITS dividend bits
	always_comb begin
		logic [SIZE_W:0]   r2;
		logic [SIZE_W-1:0] r;
		r  = rem_q;
		r2 = '0;
		for (int i = 0; i < DIG_BITS; i++) begin
			r2 = {r, dvd_q[HASH_W-1-i]};
			if (r2 >= {1'b0, div_q}) begin
				r2 = r2 - {1'b0, div_q};
			end
			r = r2[SIZE_W-1:0];
		end
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MOD_CNT_W'(MOD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << DIG_BITS;
			rem_q <= rem_nxt;
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/request_shard_router_top.sv =====
// Top level of the request shard router: stream ports, sequencer and result register.
// An item without tlast leaves s_axis_tready high and only updates the key hash.
// A last item with an error status passes through the result state into the output register;
// a routed one first waits in the divide state while the remainder unit retires 4 of 64 dividend bits a cycle.
// s_axis_tready is low from a last item's acceptance until its result is in the output register.
// Reset (arst_n, asynchronous, active low): hash to 5381, pool size to 1, no result pending.
module request_shard_router_top #(
	parameter int POOL_SLOTS = rsr_pkg::POOL_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// config
	input  logic                           cfg_we,
	input  logic [rsr_pkg::CFG_W-1:0]      cfg_wdata,	// pool_size
	// request items
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// matrix_index[31:0], row_index[63:32], column_index[95:64], key_byte[103:96]
	input  logic [rsr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// item_kind[2:0], attribute_kind[4:3], key_empty[5]
	input  logic [rsr_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	input  logic                           s_axis_tlast,	// item_last
	// routing results
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [rsr_pkg::M_TDATA_W-1:0]  m_axis_tdata,	// slot[7:0]
	output logic [rsr_pkg::M_TUSER_W-1:0]  m_axis_tuser	// status[1:0]
);
	import rsr_pkg::*;

	// largest divisor the clamped pool size can take
	localparam int MAX_DIV = (POOL_SLOTS < 511) ? POOL_SLOTS : 511;
	localparam int SIZE_W  = $clog2(MAX_DIV + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_RES  = 3'b100
	} state_t;

	state_t             state_q;
	logic [CFG_W-1:0]   pool_q;
	logic [SIZE_W-1:0]  size_eff;
	logic               acc;

	// unpacked fields
	logic [2:0]         item_kind;
	logic [1:0]         attribute_kind;
	logic [IDX_W-1:0]   matrix_index;
	logic [IDX_W-1:0]   row_index;
	logic [IDX_W-1:0]   column_index;
	logic [KEY_W-1:0]   key_byte;
	logic               key_empty;

	logic [HASH_W-1:0]  hash;
	mod_req_t           mreq;
	mod_sts_t           msts;
	logic [SIZE_W-1:0]  rem;
	status_t            route_st;
	logic [HASH_W-1:0]  route_dvd;

	status_t            res_st_q;
	logic [SLOT_W-1:0]  res_slot_q;
	logic               out_valid_q;
	logic [SLOT_W-1:0]  out_slot_q;
	status_t            out_st_q;
	logic [31:0]        rem_ext;

	assign item_kind      = s_axis_tuser[2:0];
	assign attribute_kind = s_axis_tuser[4:3];
	assign key_empty      = s_axis_tuser[5];
	assign matrix_index   = s_axis_tdata[31:0];
	assign row_index      = s_axis_tdata[63:32];
	assign column_index   = s_axis_tdata[95:64];
	assign key_byte       = s_axis_tdata[103:96];

	assign s_axis_tready = (state_q == S_IDLE);
	assign acc           = s_axis_tvalid && s_axis_tready;

	// pool size: zero counts as one, above the pool is clamped to it
	always_comb begin
		if (pool_q == '0) begin
			size_eff = SIZE_W'(1);
		end else if ({{(32-CFG_W){1'b0}}, pool_q} > 32'(POOL_SLOTS)) begin
			size_eff = SIZE_W'(MAX_DIV);
		end else begin
			size_eff = pool_q[SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= CFG_W'(1);
		end else if (cfg_we) begin
			pool_q <= cfg_wdata;
		end
	end

	rsr_hash u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (acc && !key_empty),
		.clr      (acc && s_axis_tlast),
		.key_byte (key_byte),
		.hash     (hash)
	);

	// routing decision for the last item, first match wins
	always_comb begin
		route_st  = RS_OK;
		route_dvd = '0;
		priority if (matrix_index[IDX_W-1]) begin
			route_st = RS_RANGE;
		end else if (attribute_kind == AK_INDEX || attribute_kind == AK_NAME ||
		             item_kind == IK_MATRIX) begin
			route_dvd = {{(HASH_W-IDX_W){1'b0}}, matrix_index};
		end else if (item_kind == IK_ROW || item_kind == IK_CELL) begin
			if (row_index[IDX_W-1]) begin
				route_st = RS_RANGE;
			end else begin
				route_dvd = {{(HASH_W-IDX_W){1'b0}}, matrix_index}
				          + {{(HASH_W-IDX_W){1'b0}}, row_index};
			end
		end else if (item_kind == IK_COLUMN) begin
			if (column_index[IDX_W-1]) begin
				route_st = RS_RANGE;
			end else begin
				route_dvd = {{(HASH_W-IDX_W){1'b0}}, matrix_index}
				          + {{(HASH_W-IDX_W){1'b0}}, column_index};
			end
		end else if (item_kind == IK_KV) begin
			if (key_empty) begin
				route_st = RS_NAME;
			end else begin
				route_dvd = hash;	// includes this item's byte
			end
		end else begin
			route_st = RS_UNKNOWN;
		end
	end

	assign mreq.start    = acc && s_axis_tlast && (route_st == RS_OK);
	assign mreq.dividend = route_dvd;

	rsr_mod #(
		.SIZE_W (SIZE_W)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (mreq),
		.divisor   (size_eff),
		.sts       (msts),
		.remainder (rem)
	);

	assign rem_ext = 32'(rem);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc && s_axis_tlast) begin
						state_q <= (route_st == RS_OK) ? S_DIV : S_RES;
					end
				end
				S_DIV: begin
					if (msts.done) begin
						state_q <= S_RES;
					end
				end
				S_RES: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// pending result of the current request
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && acc && s_axis_tlast) begin
			res_st_q   <= route_st;
			res_slot_q <= '0;
		end else if (state_q == S_DIV && msts.done) begin
			res_slot_q <= rem_ext[SLOT_W-1:0];
		end
	end

	// output register, refilled as soon as the previous transaction leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RES && (!out_valid_q || m_axis_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RES && (!out_valid_q || m_axis_tready)) begin
			out_slot_q <= res_slot_q;
			out_st_q   <= res_st_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_slot_q;
	assign m_axis_tuser  = out_st_q;

endmodule

// ===== rtl/rsr_checker.sv =====
// Port-level checks for the request shard router, bound to the top level.
module rsr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           s_axis_tlast,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [rsr_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input logic [rsr_pkg::M_TUSER_W-1:0]  m_axis_tuser
);
	import rsr_pkg::*;

	// a result waits until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result dropped or changed while stalled");

	// a last item closes the request: no new item next cycle
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("item taken while request still routing");

	// failed requests carry slot zero
	a_err_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != M_TUSER_W'(RS_OK)) |-> m_axis_tdata == '0)
		else $error("error status with non-zero slot");

	// a fresh result only follows a last item
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid
		|=> !m_axis_tvalid)
		else $error("result without a last item");

endmodule

bind request_shard_router_top rsr_checker u_rsr_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the request shard router: stream driver, result monitor, routing predictor.
module testbench;
	import rsr_pkg::*;

	localparam int POOL_SLOTS  = POOL_SLOTS_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE      = 40;	// cycles past the slowest routed request
	localparam int ITEMS_PER_PHASE = 195;

	// One request item as the sender sees it
	typedef struct {
		bit [2:0]        kind;
		bit [1:0]        attr;
		bit [IDX_W-1:0]  matrix;
		bit [IDX_W-1:0]  row;
		bit [IDX_W-1:0]  column;
		bit [KEY_W-1:0]  key_byte;
		bit              key_empty;
		bit              last;
		bit              drain_first;	// hold until all routes are back
	} req_item_t;

	typedef struct {
		bit [SLOT_W-1:0] slot;
		status_t         status;
	} route_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_W-1:0]      cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [S_TUSER_W-1:0]  s_axis_tuser = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic [M_TUSER_W-1:0]  m_axis_tuser;

	req_item_t       items_to_send[$];
	route_t          routes_due[$];
	req_item_t       next_item;
	bit [HASH_W-1:0] key_hash = HASH_SEED;
	bit [CFG_W-1:0]  pool_reg = 9'd1;
	int              sender_gap_max = 0;
	int              sink_stall_max = 0;
	int              send_gap = 0;
	int              sink_stall = 0;
	int              failures = 0;
	int              cycles = 0;
	int              items_taken = 0;
	int              keys_hashed = 0;
	int              status_seen[4] = '{0, 0, 0, 0};

	request_shard_router_top #(.POOL_SLOTS(POOL_SLOTS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Routing decision for a finished request; first matching rule wins
	function automatic route_t route_request(bit [2:0] kind, bit [1:0] attr,
			bit [IDX_W-1:0] mat, bit [IDX_W-1:0] row, bit [IDX_W-1:0] col,
			bit empty, bit [HASH_W-1:0] hash, bit [CFG_W-1:0] pool);
		route_t    r;
		bit [63:0] size;
		bit [63:0] rem;
		r.slot = '0;
		r.status = RS_OK;
		rem = '0;
		if (pool == 0)
			size = 64'd1;
		else if (pool > POOL_SLOTS)
			size = 64'(POOL_SLOTS);
		else
			size = 64'(pool);
		if (mat[IDX_W-1]) begin
			r.status = RS_RANGE;
		end else if (attr == AK_INDEX || attr == AK_NAME || kind == IK_MATRIX) begin
			rem = {32'b0, mat} % size;
		end else if (kind == IK_ROW || kind == IK_CELL) begin
			if (row[IDX_W-1])
				r.status = RS_RANGE;
			else
				rem = ({32'b0, mat} + {32'b0, row}) % size;
		end else if (kind == IK_COLUMN) begin
			if (col[IDX_W-1])
				r.status = RS_RANGE;
			else
				rem = ({32'b0, mat} + {32'b0, col}) % size;
		end else if (kind == IK_KV) begin
			if (empty)
				r.status = RS_NAME;
			else
				rem = hash % size;
		end else begin
			r.status = RS_UNKNOWN;
		end
		if (r.status == RS_OK)
			r.slot = rem[SLOT_W-1:0];
		return r;
	endfunction

	// Sender: one item per transaction, random gap after each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (send_gap != 0) begin
				s_axis_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (items_to_send.size() != 0 &&
					!(items_to_send[0].drain_first &&
					(routes_due.size() != 0 || (s_axis_tvalid && s_axis_tlast)))) begin
				next_item = items_to_send.pop_front();
				s_axis_tdata <= {next_item.key_byte, next_item.column, next_item.row,
					next_item.matrix};
				s_axis_tuser <= {next_item.key_empty, next_item.attr, next_item.kind};
				s_axis_tlast <= next_item.last;
				s_axis_tvalid <= 1'b1;
				send_gap <= $urandom_range(0, sender_gap_max);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: stalls for a random number of cycles after each result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_stall = 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			sink_stall = $urandom_range(0, sink_stall_max);
			if (sink_stall != 0) begin
				m_axis_tready <= 1'b0;
				sink_stall = sink_stall - 1;
			end
		end else if (!m_axis_tready) begin
			if (sink_stall == 0)
				m_axis_tready <= 1'b1;
			else
				sink_stall = sink_stall - 1;
		end
	end

	// Monitor: predict on every accepted item, check every accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				items_taken++;
				if (!s_axis_tuser[5]) begin
					key_hash = (key_hash << HASH_SHIFT) + key_hash +
						{{(HASH_W-KEY_W){s_axis_tdata[103]}}, s_axis_tdata[103:96]};
					keys_hashed++;
				end
				if (s_axis_tlast) begin
					routes_due.push_back(route_request(s_axis_tuser[2:0], s_axis_tuser[4:3],
						s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[95:64],
						s_axis_tuser[5], key_hash, pool_reg));
					key_hash = HASH_SEED;
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (routes_due.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected result: slot %0d status %0d",
							m_axis_tdata, m_axis_tuser);
				end else begin
					route_t want;
					want = routes_due.pop_front();
					status_seen[want.status]++;
					if (m_axis_tdata !== want.slot || m_axis_tuser !== want.status) begin
						failures++;
						if (failures <= 10)
							$display("route mismatch: expected slot %0d %s, got slot %0d status %0d",
								want.slot, want.status.name(), m_axis_tdata, m_axis_tuser);
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d routes outstanding", cycles, routes_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic push_item(bit [2:0] kind, bit [1:0] attr, bit [31:0] mat, bit [31:0] row,
			bit [31:0] col, bit [7:0] kb, bit empty, bit last, bit drain = 1'b0);
		req_item_t it;
		it.kind = kind;
		it.attr = attr;
		it.matrix = mat;
		it.row = row;
		it.column = col;
		it.key_byte = kb;
		it.key_empty = empty;
		it.last = last;
		it.drain_first = drain;
		items_to_send.push_back(it);
	endtask

	function automatic bit [31:0] draw_index();
		case ($urandom_range(0, 9))
			0, 1: return 32'h8000_0000 | $urandom();
			2: return 32'h7fff_ffff;
			3: return 32'd0;
			4, 5: return $urandom_range(0, 1000);
			default: return $urandom() & 32'h7fff_ffff;
		endcase
	endfunction

	// One request: mostly well-formed, some noise kinds and attributes
	task automatic queue_request(output int n_items);
		int unsigned shape;
		bit [2:0]    kind;
		bit [1:0]    attr;
		bit          empty;
		shape = $urandom_range(0, 99);
		attr = ($urandom_range(0, 99) < 85) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
		if (shape < 50) begin
			kind = IK_KV;
			n_items = $urandom_range(1, 14);
		end else if (shape < 85) begin
			kind = 3'($urandom_range(0, 3));
			n_items = $urandom_range(1, 3);
		end else begin
			kind = 3'($urandom_range(0, 7));
			attr = 2'($urandom_range(0, 3));
			n_items = $urandom_range(1, 4);
		end
		// earlier items only contribute a key byte; headers are junk
		for (int i = 0; i < n_items - 1; i++)
			push_item(3'($urandom()), 2'($urandom()), $urandom(), $urandom(), $urandom(),
				8'($urandom()), $urandom_range(0, 9) == 0, 1'b0,
				i == 0 && $urandom_range(0, 39) == 0);
		empty = $urandom_range(0, 9) == 0;
		push_item(kind, attr, draw_index(), draw_index(), draw_index(), 8'($urandom()),
			empty, 1'b1, n_items == 1 && $urandom_range(0, 39) == 0);
	endtask

	task automatic wait_idle();
		while (items_to_send.size() != 0 || s_axis_tvalid || routes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_pool(bit [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		pool_reg = value;
	endtask

	initial begin
		bit [CFG_W-1:0] pools[8];
		int             gaps[8];
		int             stalls[8];
		int             queued;
		int             n;
		pools  = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd257, 9'd2, 9'd255, 9'd0};
		gaps   = '{0, 8, 8, 0, 3, 8, 0, 8};
		stalls = '{0, 8, 0, 8, 3, 8, 0, 2};
		pools[7] = 9'($urandom_range(3, 250));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, rule precedence and the error statuses
		write_pool(9'd7);
		@(negedge clk);
		push_item(IK_MATRIX, 2'd2, 32'h7fff_ffff, 32'h0, 32'h0, 8'h00, 1'b0, 1'b1);
		push_item(IK_MATRIX, 2'd2, 32'h8000_0000, 32'h0, 32'h0, 8'hff, 1'b0, 1'b1);
		push_item(3'd7, AK_INDEX, 32'd100, 32'hffff_ffff, 32'h0, 8'h01, 1'b1, 1'b1);
		push_item(IK_KV, AK_NAME, 32'd0, 32'h0, 32'h0, 8'h00, 1'b1, 1'b1);
		push_item(IK_ROW, 2'd2, 32'd5, 32'hffff_ffff, 32'd3, 8'h10, 1'b0, 1'b1);
		push_item(IK_ROW, 2'd3, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 8'h20, 1'b0, 1'b1);
		push_item(IK_CELL, 2'd2, 32'd3, 32'd4, 32'h8000_0000, 8'h30, 1'b0, 1'b1);
		push_item(IK_COLUMN, 2'd2, 32'd1, 32'd0, 32'h8000_0000, 8'h40, 1'b0, 1'b1);
		push_item(IK_COLUMN, 2'd3, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 8'h50, 1'b0,
			1'b1);
		// multi-byte key, both signs of byte
		push_item(3'd5, 2'd1, 32'hffff_ffff, 32'h0, 32'h0, 8'h80, 1'b0, 1'b0);
		push_item(3'd0, 2'd0, 32'h0, 32'h0, 32'h0, 8'h7f, 1'b0, 1'b0);
		push_item(3'd7, 2'd3, 32'h0, 32'h0, 32'h0, 8'hff, 1'b0, 1'b0);
		push_item(IK_KV, 2'd2, 32'd9, 32'hffff_ffff, 32'hffff_ffff, 8'h55, 1'b0, 1'b1);
		// byte flagged empty is skipped by the hash
		push_item(IK_KV, 2'd2, 32'd0, 32'h0, 32'h0, 8'h12, 1'b1, 1'b0);
		push_item(IK_KV, 2'd3, 32'd0, 32'h0, 32'h0, 8'h61, 1'b0, 1'b1);
		push_item(IK_KV, 2'd2, 32'd4, 32'h0, 32'h0, 8'h61, 1'b1, 1'b1);
		push_item(IK_KV, 2'd2, 32'hffff_fffe, 32'h0, 32'h0, 8'h61, 1'b0, 1'b1);
		push_item(3'd5, 2'd2, 32'd1, 32'd1, 32'd1, 8'h00, 1'b0, 1'b1);
		push_item(3'd6, 2'd3, 32'd1, 32'd1, 32'd1, 8'h00, 1'b0, 1'b1, 1'b1);
		push_item(3'd7, 2'd2, 32'd1, 32'd1, 32'd1, 8'h00, 1'b0, 1'b1);
		push_item(IK_KV, 2'd3, 32'd0, 32'h0, 32'h0, 8'h00, 1'b0, 1'b1);
		wait_idle();

		// Random phases, each under a different pool size, with varied handshake pressure
		for (int p = 0; p < 8; p++) begin
			write_pool(pools[p]);
			sender_gap_max = gaps[p];
			sink_stall_max = stalls[p];
			@(negedge clk);
			queued = 0;
			while (queued < ITEMS_PER_PHASE) begin
				queue_request(n);
				queued += n;
			end
			wait_idle();
		end

		if (routes_due.size() != 0)
			failures += routes_due.size();
		$display("covered %0d items (%0d key bytes hashed) over 9 pool settings incl. 0, 1, 256, 511",
			items_taken, keys_hashed);
		$display("routes checked: %0d ok, %0d range, %0d name missing, %0d unknown kind",
			status_seen[RS_OK], status_seen[RS_RANGE], status_seen[RS_NAME],
			status_seen[RS_UNKNOWN]);
		if (failures == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
